>>> rtl/n2a_pkg.sv
`default_nettype none

package n2a_pkg;

    localparam int OP_W     = 3;
    localparam int VAL_W    = 64;
    localparam int CH_W     = 8;
    localparam int NIB_W    = 4;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_W    = DEC_DIGITS * NIB_W;
    localparam int CNT_W    = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS = VAL_W / BITS_PER_STEP;
    localparam int STEP_W   = 4;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [OP_W-1:0] OP_DEC   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEX8  = 3'd1;
    localparam logic [OP_W-1:0] OP_HEX16 = 3'd2;
    localparam logic [OP_W-1:0] OP_HEX32 = 3'd3;
    localparam logic [OP_W-1:0] OP_HEX64 = 3'd4;
    localparam logic [OP_W-1:0] OP_CHR   = 3'd5;

    localparam logic [CH_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CH_W-1:0] ASCII_A    = 8'h41;
    localparam logic [CH_W-1:0] ASCII_CR   = 8'h0D;
    localparam logic [CH_W-1:0] ASCII_LF   = 8'h0A;

    typedef enum logic [1:0] {
        K_DEC = 2'd0,
        K_HEX = 2'd1,
        K_CHR = 2'd2
    } t_kind;

    // data is the raw value for decimal, left aligned for hex and character
    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] ndig;
        logic [VAL_W-1:0] data;
    } t_cmd;

    function automatic logic [CH_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [CH_W-1:0] n;
        n = {{(CH_W-NIB_W){1'b0}}, nib};
        return (nib > 4'd9) ? (n - 8'd10 + ASCII_A) : (n + ASCII_ZERO);
    endfunction

    // one shift-and-add-3 step of binary to bcd conversion
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (adj[d*NIB_W +: NIB_W] >= 4'd5) begin
                adj[d*NIB_W +: NIB_W] = adj[d*NIB_W +: NIB_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

`default_nettype wire

>>> rtl/n2a_if.sv
`default_nettype none

interface n2a_in_if import n2a_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;

    modport source(output valid, op, value, input ready);
    modport sink(input valid, op, value, output ready);
endinterface

interface n2a_out_if import n2a_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source(output valid, ch, last, input ready);
    modport sink(input valid, ch, last, output ready);
endinterface

`default_nettype wire

>>> rtl/n2a_front.sv
`default_nettype none

module n2a_front import n2a_pkg::*; (
    n2a_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic w_known;

    assign i_in.ready = !i_full;

    always_comb begin
        w_known    = 1'b1;
        o_cmd.kind = K_HEX;
        o_cmd.ndig = '0;
        o_cmd.data = i_in.value;
        case (i_in.op)
            OP_DEC: begin
                o_cmd.kind = K_DEC;
                o_cmd.ndig = CNT_W'(DEC_DIGITS);
            end
            OP_HEX8: begin
                o_cmd.ndig = 5'd2;
                o_cmd.data = {i_in.value[7:0], 56'b0};
            end
            OP_HEX16: begin
                o_cmd.ndig = 5'd4;
                o_cmd.data = {i_in.value[15:0], 48'b0};
            end
            OP_HEX32: begin
                o_cmd.ndig = 5'd8;
                o_cmd.data = {i_in.value[31:0], 32'b0};
            end
            OP_HEX64: begin
                o_cmd.ndig = 5'd16;
            end
            OP_CHR: begin
                o_cmd.kind = K_CHR;
                o_cmd.ndig = 5'd1;
                o_cmd.data = {i_in.value[7:0], 56'b0};
            end
            default: begin
                // unused codes are consumed and dropped
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push = i_in.valid && !i_full && w_known;

endmodule

`default_nettype wire

>>> rtl/n2a_queue.sv
`default_nettype none

module n2a_queue import n2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_head    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/n2a_back.sv
`default_nettype none

module n2a_back import n2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    n2a_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_EMIT = 5'b01000,
        S_CHAR = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [VAL_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]   r_sr, n_sr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_crlf, n_crlf;
    logic               r_out_valid, n_out_valid;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic               r_last, n_last;

    logic               w_out_free;
    logic [BCD_W-1:0]   w_dabbled;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.ch    = r_ch;
    assign o_out.last  = r_last;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;

    // four binary bits folded into the bcd register per cycle
    always_comb begin
        w_dabbled = r_sr;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            w_dabbled = dabble_step(w_dabbled, r_bin[VAL_W-1-k]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_sr        = r_sr;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_crlf      = r_crlf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_ch        = r_ch;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_sr   = {i_head.data, {(BCD_W-VAL_W){1'b0}}};
                    n_cnt  = i_head.ndig;
                    n_crlf = (i_head.data[VAL_W-1 -: CH_W] == ASCII_LF);
                    case (i_head.kind)
                        K_DEC: begin
                            n_bin   = i_head.data;
                            n_sr    = '0;
                            n_step  = '0;
                            n_state = S_CONV;
                        end
                        K_HEX:   n_state = S_EMIT;
                        K_CHR:   n_state = S_CHAR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                n_sr   = w_dabbled;
                n_bin  = r_bin << BITS_PER_STEP;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CONV_STEPS-1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros but keep at least one digit
                if (r_sr[BCD_W-1 -: NIB_W] == '0 && r_cnt != 5'd1) begin
                    n_sr  = r_sr << NIB_W;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ch        = hex_char(r_sr[BCD_W-1 -: NIB_W]);
                    n_last      = (r_cnt == 5'd1);
                    n_sr        = r_sr << NIB_W;
                    n_cnt       = r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CHAR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_crlf) begin
                        n_ch   = ASCII_CR;
                        n_last = 1'b0;
                        n_crlf = 1'b0;
                    end else begin
                        n_ch    = r_sr[BCD_W-1 -: CH_W];
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_crlf      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_crlf      <= n_crlf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_sr   <= n_sr;
        r_cnt  <= n_cnt;
        r_step <= n_step;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

>>> rtl/number_to_ascii_formatter_unit.sv
`default_nettype none

// Formats one unsigned 64-bit value per input transfer as ASCII: decimal without
// leading zeros, zero-padded uppercase hex of 2/4/8/16 digits, or a raw character
// where a line feed goes out as carriage return then line feed. Each character is
// one output transfer, with last set on the final one; op codes 6 and 7 are taken
// and produce nothing. Input transfers land in a two-deep command queue, so up to
// two items are taken while the formatter works. The formatter handles one item
// at a time: hex passes a start state and then emits one character per digit,
// a character emits a carriage return first if it is a line feed and then
// itself, and decimal passes a start state, shift-add-3 conversion at four bits
// per cycle, a scan that drops leading zeros one at a time, a step to leave
// the scan and then the printed digits; output stalls hold the emitting states.
module number_to_ascii_formatter_unit import n2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    n2a_in_if.sink    i_in,
    n2a_out_if.source o_out
);

    t_cmd w_push_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    n2a_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    n2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    n2a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/n2a_check.sv
`default_nettype none

module n2a_check import n2a_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire logic [CH_W-1:0] i_out_ch,
    input wire logic            i_out_last
);

    // held output transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ch)
            && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // only hex/decimal digits or the carriage return of a line feed are non-final
    a_mid_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |->
            (i_out_ch >= ASCII_ZERO && i_out_ch <= 8'h39)
            || (i_out_ch >= ASCII_A && i_out_ch <= 8'h46)
            || (i_out_ch == ASCII_CR))
        else $error("unexpected non-final character");

    // a carriage return that is not final is always followed by a line feed
    a_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last && i_out_ch == ASCII_CR
            ##1 i_out_valid |-> i_out_ch == ASCII_LF && i_out_last)
        else $error("carriage return not followed by line feed");

endmodule

bind number_to_ascii_formatter_unit n2a_check u_n2a_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ch    (o_out.ch),
    .i_out_last  (o_out.last)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import n2a_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_char_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    n2a_in_if  in_if();
    n2a_out_if out_if();

    number_to_ascii_formatter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    t_char_exp pending_chars[$];
    int        mismatch_count = 0;
    logic      idle_en;
    logic      hold_req;

    logic [OP_W-1:0] hex_ops [4] = '{OP_HEX8, OP_HEX16, OP_HEX32, OP_HEX64};

    function automatic logic [CH_W-1:0] nibble_ascii(input logic [NIB_W-1:0] nib);
        if (nib > 4'd9) begin
            return ASCII_A + CH_W'(nib) - 8'd10;
        end
        return ASCII_ZERO + CH_W'(nib);
    endfunction

    // queues up the characters one input item should produce
    function automatic void predict_chars(input logic [OP_W-1:0] op,
                                          input logic [VAL_W-1:0] value);
        logic [CH_W-1:0]  digits [DEC_DIGITS];
        logic [VAL_W-1:0] rem;
        int               ndig;
        t_char_exp        c;
        ndig = 0;
        case (op)
            OP_DEC: begin
                rem = value;
                do begin
                    digits[ndig] = ASCII_ZERO + CH_W'(rem % 10);
                    rem = rem / 10;
                    ndig++;
                end while (rem != 0 && ndig < DEC_DIGITS);
                for (int k = ndig - 1; k >= 0; k--) begin
                    c.ch = digits[k];
                    c.last = (k == 0);
                    pending_chars.push_back(c);
                end
            end
            OP_HEX8, OP_HEX16, OP_HEX32, OP_HEX64: begin
                case (op)
                    OP_HEX8:  ndig = 2;
                    OP_HEX16: ndig = 4;
                    OP_HEX32: ndig = 8;
                    default:  ndig = 16;
                endcase
                for (int k = 0; k < ndig; k++) begin
                    c.ch = nibble_ascii(value[4*(ndig-1-k) +: NIB_W]);
                    c.last = (k == ndig - 1);
                    pending_chars.push_back(c);
                end
            end
            OP_CHR: begin
                if (value[CH_W-1:0] == ASCII_LF) begin
                    c.ch = ASCII_CR;
                    c.last = 1'b0;
                    pending_chars.push_back(c);
                end
                c.ch = value[CH_W-1:0];
                c.last = 1'b1;
                pending_chars.push_back(c);
            end
            default: begin
                // unused codes produce nothing
            end
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        v = {$urandom, $urandom};
        // shorter magnitudes give every decimal length a chance
        if ($urandom_range(0, 1) == 0) begin
            v = v >> $urandom_range(0, VAL_W - 1);
        end
        return v;
    endfunction

    // offers one item and returns once it has been transferred
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= value;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        predict_chars(op, value);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_decimal_edges();
        send_item(OP_DEC, 64'd0);
        send_item(OP_DEC, 64'd9);
        send_item(OP_DEC, 64'd10);
        send_item(OP_DEC, 64'd9999999999999999999);
        send_item(OP_DEC, 64'd10000000000000000000);
        send_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_DEC, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_hex_sizes();
        for (int i = 0; i < 4; i++) begin
            send_item(hex_ops[i], 64'd0);
            // upper bits beyond the chosen size must be dropped
            send_item(hex_ops[i], 64'hFEDC_BA98_7654_3210);
        end
        send_item(OP_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_characters();
        send_item(OP_CHR, 64'h0000_0000_0000_0041);
        send_item(OP_CHR, {56'hFF_FFFF_FFFF_FFFF, ASCII_LF});
        send_item(OP_CHR, {56'd0, ASCII_CR});
        send_item(OP_CHR, 64'd0);
        send_item(OP_CHR, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_unused_ops();
        send_item(OP_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_RSVD7, 64'h0123_4567_89AB_CDEF);
        send_item(OP_HEX8, 64'h5A);
    endtask

    task automatic test_random(input int count);
        int               sent;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 15);
            value = rand_value();
            if (pick < 5) begin
                op = OP_DEC;
            end else if (pick < 11) begin
                op = hex_ops[$urandom_range(0, 3)];
            end else if (pick < 15) begin
                op = OP_CHR;
                if ($urandom_range(0, 3) == 0) begin
                    value[CH_W-1:0] = ASCII_LF;
                end
            end else begin
                op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
            end
            send_item(op, value);
            if (pick < 15) begin
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_item(i[0] ? OP_HEX64 : OP_DEC, rand_value());
        end
        in_if.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_streaming();
        idle_en <= 1'b0;
        for (int i = 0; i < 20; i++) begin
            send_item(i[0] ? hex_ops[$urandom_range(0, 3)] : OP_DEC, rand_value());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.op     <= OP_DEC;
        in_if.value  <= '0;
        idle_en      <= 1'b1;
        hold_req     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_decimal_edges();
        test_hex_sizes();
        test_characters();
        test_unused_ops();
        test_random(120);
        test_backpressure();
        test_streaming();

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("number_to_ascii_formatter_unit test passed");
        end else begin
            $display("number_to_ascii_formatter_unit test failed");
        end
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req     <= 1'b0;
                out_if.ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : char_check
        t_char_exp exp_c;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_chars.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected transfer: ch=%h last=%b", out_if.ch, out_if.last);
                end
                mismatch_count++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (out_if.ch !== exp_c.ch || out_if.last !== exp_c.last) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("mismatch: expected ch=%h last=%b, got ch=%h last=%b",
                                 exp_c.ch, exp_c.last, out_if.ch, out_if.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("number_to_ascii_formatter_unit test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/n2a_pkg.sv
rtl/n2a_if.sv
rtl/n2a_front.sv
rtl/n2a_queue.sv
rtl/n2a_back.sv
rtl/number_to_ascii_formatter_unit.sv
rtl/n2a_check.sv
verif/tb_top.sv
